// File: sv/shift_add_float_alu_defines.svh
// Assertion macros for the shift-add float ALU.
`ifndef SHIFT_ADD_FLOAT_ALU_DEFINES_SVH
`define SHIFT_ADD_FLOAT_ALU_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define SAFA_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define SAFA_ASSERT_NXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/safa_pkg.sv
// Package with opcodes, states and constants of the shift-add float ALU.
`default_nettype none
package safa_pkg;
  typedef enum logic [2:0] {
    OP_UMUL16 = 3'd0,
    OP_SMUL32 = 3'd1,
    OP_FADD   = 3'd2,
    OP_FSUB   = 3'd3,
    OP_FMUL   = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ALGN = 5'b00100,
    ST_NORM = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam int MulSteps = 32;
  localparam logic [31:0] HIDDEN   = 32'h4000_0000;
  localparam logic [31:0] FRACMASK = 32'h3FFF_FF80;
  localparam logic [31:0] MANTMASK = 32'h007F_FFFF;
  localparam logic [31:0] SIGNMASK = 32'h8000_0000;
  localparam logic [31:0] EXPMASK  = 32'h7F80_0000;
  localparam logic [9:0]  BIAS     = 10'd127;
endpackage
`default_nettype wire

// File: sv/shift_add_float_alu.sv
// Sequencing, from the accepting edge to out_tvalid: unused opcodes and fmul with a zero
// operand go straight to done; umul16/smul32 run 32 shift-add steps; fmul runs the 32 steps
// plus one or two normalize shifts; fadd/fsub align, run normalize shifts, then pack.
// One transaction at a time: in_tready is high only in idle, so an item holds the unit
// until its result moves to the output register, including any stall on a full output.
// Reset (rst_n low, sync) returns the sequencer to idle and drops any pending result.
`default_nettype none
module shift_add_float_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: opcode[2:0], operand_a[34:3], operand_b[66:35], zero fill to 72
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: result_bits[63:0]
  output logic [63:0]      out_tdata
);
  `include "shift_add_float_alu_defines.svh"

  localparam int STEPS = safa_pkg::MulSteps;
  localparam int CW = $clog2(STEPS + 1);

  safa_pkg::state_t st_r, st_nxt;
  logic [2:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [63:0] acc_r;      // multiply product: high half in [63:32]
  logic [31:0] mcand_r;    // multiplicand magnitude
  logic [CW-1:0] cnt_r;
  logic        neg_r;      // smul result sign
  logic [31:0] fr_r;
  logic [9:0]  ex_r;       // wraps; only low 8 bits packed
  logic        sb_r;
  logic [63:0] wres_r;     // result being built
  logic [63:0] res_r;      // output register
  logic        ov_r;

  // unpack helpers
  function automatic logic [31:0] unp_fr(input logic [31:0] x);
    logic [31:0] f;
    f = ((x << 7) & safa_pkg::FRACMASK) | safa_pkg::HIDDEN;
    if (x[30:0] == '0) return '0;
    return x[31] ? (32'd0 - f) : f;
  endfunction
  function automatic logic [9:0] unp_ex(input logic [31:0] x);
    if (x[30:0] == '0) return '0;
    return {2'b00, x[30:23]} - safa_pkg::BIAS;
  endfunction
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [9:0] n);
    logic [4:0] s;
    s = (n > 10'd31) ? 5'd31 : n[4:0];
    return $unsigned($signed(x) >>> s);
  endfunction

  wire [2:0]  i_op = in_tdata[2:0];
  wire [31:0] i_a  = in_tdata[34:3];
  wire [31:0] i_b  = in_tdata[66:35];

  // adder for the shift-add multiply step
  logic [32:0] add_s;
  always_comb begin
    add_s = {1'b0, acc_r[63:32]} + {1'b0, (acc_r[0] ? mcand_r : 32'd0)};
  end

  wire [9:0] ea = unp_ex(a_r);
  wire [9:0] eb = unp_ex(b_r);
  wire [31:0] fa = unp_fr(a_r);
  wire [31:0] fb = unp_fr(b_r);
  wire ea_gt = $signed(ea) > $signed(eb);
  wire ea_lt = $signed(ea) < $signed(eb);
  wire [9:0] dab = ea - eb;
  wire [9:0] dba = eb - ea;
  wire [31:0] fa_al = ea_lt ? asr(fa, dba) : fa;
  wire [31:0] fb_al = ea_gt ? asr(fb, dab) : fb;
  wire [9:0] emax = ea_lt ? eb : ea;
  wire [31:0] sumv = (op_r == safa_pkg::OP_FSUB) ? (asr(fa_al, 10'd1) - asr(fb_al, 10'd1))
                                                : (asr(fa_al, 10'd1) + asr(fb_al, 10'd1));

  wire norm_done = (fr_r[30] != sb_r) || (cnt_r == CW'(STEPS));
  wire fmul_op = (op_r == safa_pkg::OP_FMUL);
  wire [31:0] packfr = (!fmul_op && sb_r) ? (32'd0 - fr_r) : fr_r;
  wire [31:0] packed_w = (fmul_op ? ((a_r ^ b_r) & safa_pkg::SIGNMASK)
                                  : (sb_r ? safa_pkg::SIGNMASK : 32'd0))
                       | (({22'd0, ex_r} + 32'd127) << 23 & safa_pkg::EXPMASK)
                       | (((packfr & ~safa_pkg::HIDDEN) >> 7) & safa_pkg::MANTMASK);
  wire [63:0] prod = {add_s, acc_r[31:1]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      safa_pkg::ST_IDLE: if (in_tvalid) begin
        case (i_op)
          safa_pkg::OP_UMUL16, safa_pkg::OP_SMUL32: st_nxt = safa_pkg::ST_MUL;
          safa_pkg::OP_FADD, safa_pkg::OP_FSUB: st_nxt = safa_pkg::ST_ALGN;
          safa_pkg::OP_FMUL: st_nxt = (unp_fr(i_a) == '0 || unp_fr(i_b) == '0)
                                      ? safa_pkg::ST_DONE : safa_pkg::ST_MUL;
          default: st_nxt = safa_pkg::ST_DONE;
        endcase
      end
      safa_pkg::ST_MUL: if (cnt_r == CW'(STEPS - 1))
        st_nxt = fmul_op ? safa_pkg::ST_NORM : safa_pkg::ST_DONE;
      safa_pkg::ST_ALGN: st_nxt = (sumv == '0) ? safa_pkg::ST_DONE : safa_pkg::ST_NORM;
      safa_pkg::ST_NORM: if (norm_done) st_nxt = safa_pkg::ST_DONE;
      safa_pkg::ST_DONE: if (!ov_r || out_tready) st_nxt = safa_pkg::ST_IDLE;
      default: st_nxt = safa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= safa_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // a new result replaces the one leaving in the same cycle
      if (st_r == safa_pkg::ST_DONE && st_nxt == safa_pkg::ST_IDLE) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      safa_pkg::ST_IDLE: begin
        op_r <= i_op; a_r <= i_a; b_r <= i_b; cnt_r <= '0; wres_r <= '0;
        // load magnitudes: multiplier in acc low half
        if (i_op == safa_pkg::OP_UMUL16) begin
          mcand_r <= {16'd0, i_a[15:0]}; acc_r <= {48'd0, i_b[15:0]}; neg_r <= 1'b0;
        end else if (i_op == safa_pkg::OP_SMUL32) begin
          mcand_r <= i_a[31] ? 32'd0 - i_a : i_a;
          acc_r <= {32'd0, (i_b[31] ? 32'd0 - i_b : i_b)};
          neg_r <= i_a[31] ^ i_b[31];
        end else begin
          mcand_r <= ((i_a << 7) & safa_pkg::FRACMASK) | safa_pkg::HIDDEN;
          acc_r <= {32'd0, ((i_b << 7) & safa_pkg::FRACMASK) | safa_pkg::HIDDEN};
          neg_r <= 1'b0;
        end
      end
      safa_pkg::ST_MUL: begin
        // one shift-add step per cycle through the multiply adder
        acc_r <= prod;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          if (op_r == safa_pkg::OP_UMUL16) wres_r <= prod;
          else if (op_r == safa_pkg::OP_SMUL32) wres_r <= neg_r ? 64'd0 - prod : prod;
          fr_r <= prod[63:32]; sb_r <= prod[63]; ex_r <= ea + eb + 10'd2;
          cnt_r <= '0;
        end
      end
      safa_pkg::ST_ALGN: begin
        fr_r <= sumv; sb_r <= sumv[31]; ex_r <= emax + 10'd1; cnt_r <= '0;
      end
      safa_pkg::ST_NORM: begin
        // one left shift per step until bit 30 differs from the sign or the step cap is reached
        if (norm_done) wres_r <= {32'd0, packed_w};
        else begin
          fr_r <= fr_r << 1; ex_r <= ex_r - 10'd1; cnt_r <= cnt_r + 1'b1;
        end
      end
      safa_pkg::ST_DONE: begin
        // move the result out once the output register is free
        if (!ov_r || out_tready) res_r <= wres_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (st_r == safa_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = res_r;

  `SAFA_ASSERT_IMP(a_busy, clk, rst_n, st_r != safa_pkg::ST_IDLE, !in_tready)
  `SAFA_ASSERT_NXT(a_cnt, clk, rst_n, st_r == safa_pkg::ST_MUL, cnt_r <= CW'(STEPS))
  `SAFA_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
`default_nettype wire
